// ===== design/fwc_pkg.sv =====
// fwc_pkg: shared types and constants for the feathered wipe compositor
// no dependencies; imported by every module of the block

package fwc_pkg;

  localparam int POS_W = 12;
  localparam int PIX_PER_BYTE = 8;
  localparam int EDGE_W = 10;
  localparam int FEATHER_W = 7;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    DIR_R2L = 2'd0,
    DIR_L2R = 2'd1,
    DIR_B2T = 2'd2,
    DIR_T2B = 2'd3
  } dir_t;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATHER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR     = 2'd2;

  typedef struct packed {
    logic force_new;
    logic force_old;
  } fwc_mode_t;

endpackage

// ===== design/fwc_lane.sv =====
// fwc_lane: per-pixel sweep position and old/new/dither selection
// depends on fwc_pkg

module fwc_lane import fwc_pkg::*; #(
  parameter int LANE_IDX    = 0,
  parameter int WIDTH_BYTES = 100,
  parameter int HEIGHT      = 480
) (
  input  logic [8:0]        row_index,
  input  logic [6:0]        byte_column,
  input  dir_t              dir,
  input  logic [EDGE_W-1:0] edge_pos,
  input  pos_t              band_start,
  input  logic              old_bit,
  input  logic              new_bit,
  output logic              pix
);

  localparam logic [2:0] LANE_BITS = 3'(LANE_IDX);
  localparam pos_t W_LAST = POS_W'(WIDTH_BYTES * PIX_PER_BYTE - 1);
  localparam pos_t H_LAST = POS_W'(HEIGHT - 1);

  pos_t x_pos;
  pos_t row_pos;
  pos_t pos;
  pos_t edge_s;

  assign x_pos   = $signed({2'b00, byte_column, LANE_BITS});
  assign row_pos = $signed({3'b000, row_index});
  assign edge_s  = $signed({2'b00, edge_pos});

  always_comb begin
    unique case (dir)
      DIR_R2L: pos = x_pos;
      DIR_L2R: pos = W_LAST - x_pos;
      DIR_B2T: pos = row_pos;
      DIR_T2B: pos = H_LAST - row_pos;
      default: pos = x_pos;
    endcase
  end

  always_comb begin
    priority if (pos < band_start) begin
      pix = old_bit;
    end else if (pos >= edge_s) begin
      pix = new_bit;
    end else begin
      // parity of offset from band start
      pix = (pos[0] ^ band_start[0]) ? old_bit : new_bit;
    end
  end

endmodule

// ===== design/fwc_merge.sv =====
// fwc_merge: picks the lane pixels or the whole old or new byte as the result byte and registers it
// depends on fwc_pkg

module fwc_merge import fwc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  fwc_mode_t               mode,
  input  logic [PIX_PER_BYTE-1:0] old_byte,
  input  logic [PIX_PER_BYTE-1:0] new_byte,
  input  logic [PIX_PER_BYTE-1:0] lane_bits,
  output logic                    out_valid,
  output logic [PIX_PER_BYTE-1:0] out_byte
);

  logic                    out_valid_r;
  logic [PIX_PER_BYTE-1:0] out_byte_r;
  logic [PIX_PER_BYTE-1:0] out_byte_nxt;

  always_comb begin
    priority if (mode.force_new) begin
      out_byte_nxt = new_byte;
    end else if (mode.force_old) begin
      out_byte_nxt = old_byte;
    end else begin
      out_byte_nxt = lane_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

endmodule

// ===== design/feathered_wipe_compositor_core.sv =====
// feathered_wipe_compositor_core: top level of the wipe compositor
// depends on fwc_pkg, fwc_lane, fwc_merge
//
// usage
//   input channel: drive start with in_row_index, in_byte_column, in_old_byte and
//   in_new_byte; a transaction is taken at each clock edge with start high and
//   busy low. busy is low whenever the block is out of reset, so one byte can
//   enter every cycle.
//   result channel: out_valid is high for one cycle with out_byte, once the transaction
//   has passed the input register and the output register. throughput is one byte per clock, set by the
//   input register and the output register around eight pixel lanes that
//   work on the byte at once. the receiver cannot stall; results are never held.
//   config channel: cfg_valid/cfg_ready with cfg_index (0 edge, 1 feather,
//   2 direction) and cfg_data; write only while no transaction is in flight.
//   cfg_ready is high whenever out of reset.
//   reset: synchronous, active low; clears the config registers and the pipeline
//   valid bits. all config registers come up at 0, so every byte shows new.

module feathered_wipe_compositor_core import fwc_pkg::*; #(
  parameter int WIDTH_BYTES = 100,
  parameter int HEIGHT      = 480
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [8:0]            in_row_index,
  input  logic [6:0]            in_byte_column,
  input  logic [7:0]            in_old_byte,
  input  logic [7:0]            in_new_byte,
  output logic                  out_valid,
  output logic [7:0]            out_byte,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [EDGE_W:0] SPAN_H = (EDGE_W+1)'(WIDTH_BYTES * PIX_PER_BYTE);
  localparam logic [EDGE_W:0] SPAN_V = (EDGE_W+1)'(HEIGHT);

  logic [EDGE_W-1:0]    edge_r;
  logic [FEATHER_W-1:0] feather_r;
  dir_t                 dir_r;

  logic                    s1_valid_r;
  fwc_mode_t               s1_mode_r;
  fwc_mode_t               s1_mode_nxt;
  logic [8:0]              s1_row_r;
  logic [6:0]              s1_bcol_r;
  logic [PIX_PER_BYTE-1:0] s1_old_r;
  logic [PIX_PER_BYTE-1:0] s1_new_r;

  logic                    accept;
  logic                    horiz;
  logic [EDGE_W:0]         span;
  pos_t                    band_start;
  logic [PIX_PER_BYTE-1:0] lane_bits;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;
  assign accept    = start & ~busy;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r    <= '0;
      feather_r <= '0;
      dir_r     <= DIR_R2L;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EDGE:    edge_r    <= cfg_data[EDGE_W-1:0];
        CFG_FEATHER: feather_r <= cfg_data[FEATHER_W-1:0];
        CFG_DIR:     dir_r     <= dir_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  assign horiz = (dir_r == DIR_R2L) || (dir_r == DIR_L2R);
  assign span  = horiz ? SPAN_H : SPAN_V;

  always_comb begin
    s1_mode_nxt.force_new = (edge_r == '0);
    s1_mode_nxt.force_old = ({1'b0, edge_r} >= span);
  end

  assign band_start = $signed({2'b00, edge_r}) - $signed({5'b00000, feather_r});

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r <= s1_mode_nxt;
      s1_row_r  <= in_row_index;
      s1_bcol_r <= in_byte_column;
      s1_old_r  <= in_old_byte;
      s1_new_r  <= in_new_byte;
    end
  end

  // one lane per pixel, lane 0 is the leftmost pixel (bit 7)
  for (genvar b = 0; b < PIX_PER_BYTE; b++) begin : g_lane
    fwc_lane #(
      .LANE_IDX    (b),
      .WIDTH_BYTES (WIDTH_BYTES),
      .HEIGHT      (HEIGHT)
    ) u_lane (
      .row_index   (s1_row_r),
      .byte_column (s1_bcol_r),
      .dir         (dir_r),
      .edge_pos    (edge_r),
      .band_start  (band_start),
      .old_bit     (s1_old_r[PIX_PER_BYTE-1-b]),
      .new_bit     (s1_new_r[PIX_PER_BYTE-1-b]),
      .pix         (lane_bits[PIX_PER_BYTE-1-b])
    );
  end

  fwc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .mode      (s1_mode_r),
    .old_byte  (s1_old_r),
    .new_byte  (s1_new_r),
    .lane_bits (lane_bits),
    .out_valid (out_valid),
    .out_byte  (out_byte)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(accept, 2))
    else $error("result strobe does not follow transaction by two cycles");

  a_force_new: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_mode_r.force_new |=> out_byte == $past(s1_new_r))
    else $error("zero edge did not pass the new byte");

  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !(s1_mode_r.force_new && s1_mode_r.force_old))
    else $error("both full-frame modes set");

endmodule
